// File: rtl/core/eaut_pkg.sv
// Package for the encoder angle unwrap tracker.
// Holds field widths, unwrap constants and configuration register codes.
// No dependencies.
package eaut_pkg;

	localparam int unsigned ANGLE_W    = 12;
	localparam int unsigned POS_W      = 32;
	localparam int unsigned WINDOW_W   = 10;
	localparam int unsigned CFG_DATA_W = 12;

	// Input tdata: raw_angle, padded to 16 bits
	localparam int unsigned S_TDATA_W  = 16;
	// Output tdata: angle_counts, position_counts, speed_counts, padded to 80 bits
	localparam int unsigned M_TDATA_W  = 80;
	localparam int unsigned M_PAD_W    = M_TDATA_W - ANGLE_W - 2 * POS_W;

	// Step arithmetic runs on 14-bit signed values
	localparam int unsigned STEP_W     = 14;
	localparam logic signed [STEP_W-1:0] UNWRAP_LIMIT    = 14'sd2000;
	localparam logic signed [STEP_W-1:0] COUNTS_PER_TURN = 14'sd4096;

	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 10'd20;

	typedef enum logic [0:0] {
		CFG_ZERO_OFFSET  = 1'b0,
		CFG_SPEED_WINDOW = 1'b1
	} cfg_reg_t;

	// Unwrapped step between two corrected angles
	function automatic logic signed [STEP_W-1:0] unwrap_step(
		input logic [ANGLE_W-1:0] angle,
		input logic [ANGLE_W-1:0] prev
	);
		logic signed [STEP_W-1:0] diff;
		diff = $signed({2'b00, angle}) - $signed({2'b00, prev});
		if (diff > UNWRAP_LIMIT) begin
			return diff - COUNTS_PER_TURN;
		end else if (diff < -UNWRAP_LIMIT) begin
			return diff + COUNTS_PER_TURN;
		end
		return diff;
	endfunction

endpackage

// File: rtl/core/encoder_angle_unwrap_tracker.sv
// Multi-turn tracker for a 12-bit absolute angle encoder.
// Depends on eaut_pkg.

// One result per sample, one sample per cycle unless the output stalls.
// Each accepted raw angle is offset-corrected, unwrapped against the
// previous corrected angle and accumulated into a 32-bit wrapping position; the
// result is registered in the cycle after the input transaction and holds until it
// is taken. s_tready is high whenever the output register is empty or being
// drained, so with m_tready held high the block sustains a transaction every
// cycle. The speed is kept as a running window sum, so a completed window
// reports it in the same cycle without a second wide subtract. Configuration
// writes are always ready and take effect at the next sample.
module encoder_angle_unwrap_tracker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [eaut_pkg::S_TDATA_W-1:0] s_tdata,   // [11:0] raw_angle
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [eaut_pkg::M_TDATA_W-1:0] m_tdata,   // [11:0] angle_counts,
	                                                  // [43:12] position_counts,
	                                                  // [75:44] speed_counts
	output logic                          m_tuser,   // [0] speed_updated
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  eaut_pkg::cfg_reg_t            cfg_index,
	input  logic [eaut_pkg::CFG_DATA_W-1:0] cfg_data
);
	import eaut_pkg::*;

	logic [ANGLE_W-1:0]         zero_offset_q;
	logic [WINDOW_W-1:0]        speed_window_q;

	logic [ANGLE_W-1:0]         prev_angle_q;
	logic signed [POS_W-1:0]    position_q;
	logic signed [POS_W-1:0]    window_delta_q;   // position change since window start
	logic [WINDOW_W-1:0]        window_count_q;
	logic signed [POS_W-1:0]    speed_q;

	logic                       out_valid_q;
	logic [ANGLE_W-1:0]         out_angle_q;
	logic signed [POS_W-1:0]    out_position_q;
	logic signed [POS_W-1:0]    out_speed_q;
	logic                       out_updated_q;

	logic                       in_xfer;
	logic [ANGLE_W-1:0]         angle_c;
	logic signed [STEP_W-1:0]   step_c;
	logic signed [POS_W-1:0]    step_ext_c;
	logic signed [POS_W-1:0]    position_c;
	logic signed [POS_W-1:0]    delta_c;
	logic [WINDOW_W:0]          count_next_c;
	logic                       window_done_c;

	assign s_tready  = !out_valid_q || m_tready;
	assign in_xfer   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		angle_c       = s_tdata[ANGLE_W-1:0] - zero_offset_q;
		step_c        = unwrap_step(angle_c, prev_angle_q);
		step_ext_c    = {{(POS_W-STEP_W){step_c[STEP_W-1]}}, step_c};
		position_c    = position_q + step_ext_c;
		delta_c       = window_delta_q + step_ext_c;
		count_next_c  = {1'b0, window_count_q} + 1'b1;
		// A window of zero completes on every sample; one shortened below the current count completes on the next sample
		window_done_c = count_next_c >= {1'b0, speed_window_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_offset_q  <= '0;
			speed_window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ZERO_OFFSET:  zero_offset_q  <= cfg_data[ANGLE_W-1:0];
				CFG_SPEED_WINDOW: speed_window_q <= cfg_data[WINDOW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_angle_q   <= '0;
			position_q     <= '0;
			window_delta_q <= '0;
			window_count_q <= '0;
			speed_q        <= '0;
		end else if (in_xfer) begin
			prev_angle_q <= angle_c;
			position_q   <= position_c;
			if (window_done_c) begin
				window_count_q <= '0;
				window_delta_q <= '0;
				speed_q        <= delta_c;
			end else begin
				window_count_q <= count_next_c[WINDOW_W-1:0];
				window_delta_q <= delta_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_angle_q    <= angle_c;
			out_position_q <= position_c;
			out_speed_q    <= window_done_c ? delta_c : speed_q;
			out_updated_q  <= window_done_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_speed_q, out_position_q, out_angle_q};
	assign m_tuser  = out_updated_q;

endmodule

// File: rtl/core/eaut_checker.sv
// Port-level checker for encoder_angle_unwrap_tracker, bound to the top level.
// Depends on eaut_pkg.
module eaut_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [eaut_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser,
	input logic                          cfg_ready
);
	import eaut_pkg::*;

	logic [ANGLE_W-1:0]      last_angle_q;
	logic signed [POS_W-1:0] last_position_q;
	logic signed [POS_W-1:0] last_speed_q;
	logic                    out_xfer;
	logic [ANGLE_W-1:0]      angle_w;
	logic signed [POS_W-1:0] position_w;
	logic signed [POS_W-1:0] speed_w;
	logic signed [STEP_W-1:0] step_w;
	logic signed [POS_W-1:0] expect_pos_w;

	assign out_xfer     = m_tvalid && m_tready;
	assign angle_w      = m_tdata[ANGLE_W-1:0];
	assign position_w   = m_tdata[ANGLE_W+POS_W-1:ANGLE_W];
	assign speed_w      = m_tdata[ANGLE_W+2*POS_W-1:ANGLE_W+POS_W];
	assign step_w       = unwrap_step(angle_w, last_angle_q);
	assign expect_pos_w = last_position_q + {{(POS_W-STEP_W){step_w[STEP_W-1]}}, step_w};

	// Every output transaction follows exactly one input, so tracking starts from zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_angle_q    <= '0;
			last_position_q <= '0;
			last_speed_q    <= '0;
		end else if (out_xfer) begin
			last_angle_q    <= angle_w;
			last_position_q <= position_w;
			last_speed_q    <= speed_w;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output changed while stalled");

	a_position_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> position_w == expect_pos_w)
		else $error("position does not follow unwrapped angle step");

	a_speed_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !m_tuser |-> speed_w == last_speed_q)
		else $error("speed changed without update flag");

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready && cfg_ready)
		else $error("input blocked while output empty");

	// an accepted sample always shows up at the output next cycle
	a_input_fills: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("input transaction produced no result");

endmodule

bind encoder_angle_unwrap_tracker eaut_checker u_eaut_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.cfg_ready (cfg_ready)
);

// File: tb/tb_encoder_angle_unwrap_tracker.sv
// Testbench for encoder_angle_unwrap_tracker: streams raw angle samples through the block
// and checks every result against a multi-turn tracking predictor kept in the bench.
// Depends on eaut_pkg and the block's RTL.
module tb_encoder_angle_unwrap_tracker;
	import eaut_pkg::*;

	localparam int TURN_COUNTS     = 4096;
	localparam int STEP_LIMIT      = 2000;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int PHASES          = 11;

	// Unwrap edges: steps of exactly +-2000 stay, +-2001 fold by a turn
	localparam logic [ANGLE_W-1:0] RAMP_EDGES [12] = '{
		12'd4095, 12'd0, 12'd2000, 12'd4000, 12'd1999, 12'd3999,
		12'd1999, 12'd0, 12'd2001, 12'd2048, 12'd1, 12'd4095
	};

	// 12'hC05 checks that only the low window bits are kept
	localparam logic [CFG_DATA_W-1:0] PHASE_WINDOWS [PHASES] = '{
		12'd1023, 12'd2, 12'd20, 12'd1, 12'd0, 12'hC05,
		12'd64, 12'd3, 12'd1023, 12'd7, 12'd100
	};

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [POS_W-1:0]   position;
		logic [POS_W-1:0]   speed;
		logic               speed_new;
	} track_result_t;

	class multiturn_checker;
		logic [ANGLE_W-1:0]  zero_offset;
		logic [WINDOW_W-1:0] speed_window;
		logic [ANGLE_W-1:0]  last_angle;
		logic [POS_W-1:0]    position;
		logic [POS_W-1:0]    window_base;
		logic [WINDOW_W-1:0] window_fill;
		logic [POS_W-1:0]    speed;
		track_result_t       due_results[$];
		int unsigned         errors;
		int unsigned         checked;

		function new();
			zero_offset  = '0;
			speed_window = WINDOW_RESET;
			last_angle   = '0;
			position     = '0;
			window_base  = '0;
			window_fill  = '0;
			speed        = '0;
			errors       = 0;
			checked      = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_ZERO_OFFSET:  zero_offset  = value[ANGLE_W-1:0];
				CFG_SPEED_WINDOW: speed_window = value[WINDOW_W-1:0];
			endcase
		endfunction

		// Advance the tracking state by one accepted sample and queue its result
		function void note_sample(logic [ANGLE_W-1:0] raw);
			logic [ANGLE_W-1:0] angle;
			int                 step;
			int unsigned        fill_next;
			track_result_t      r;
			angle = raw - zero_offset;
			step  = int'(angle) - int'(last_angle);
			if (step > STEP_LIMIT) begin
				step -= TURN_COUNTS;
			end else if (step < -STEP_LIMIT) begin
				step += TURN_COUNTS;
			end
			last_angle = angle;
			position   = position + POS_W'(step);
			fill_next  = window_fill + 1;
			// a window of zero completes on every sample
			r.speed_new = (fill_next >= speed_window);
			if (r.speed_new) begin
				window_fill = '0;
				speed       = position - window_base;
				window_base = position;
			end else begin
				window_fill = fill_next[WINDOW_W-1:0];
			end
			r.angle    = angle;
			r.position = position;
			r.speed    = speed;
			due_results.push_back(r);
		endfunction

		task report_mismatch(string what, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
			errors++;
			if (errors <= 40) begin
				$display("mismatch on result %0d, %s: got 0x%08h, want 0x%08h",
					checked, what, got, want);
			end
		endtask

		task check_result(logic [M_TDATA_W-1:0] data, logic flag);
			track_result_t want;
			checked++;
			if (due_results.size() == 0) begin
				report_mismatch("result with nothing pending", data[POS_W-1:0], '0);
				return;
			end
			want = due_results.pop_front();
			if (data[ANGLE_W-1:0] !== want.angle) begin
				report_mismatch("angle_counts", POS_W'(data[ANGLE_W-1:0]), POS_W'(want.angle));
			end
			if (data[ANGLE_W +: POS_W] !== want.position) begin
				report_mismatch("position_counts", data[ANGLE_W +: POS_W], want.position);
			end
			if (data[ANGLE_W + POS_W +: POS_W] !== want.speed) begin
				report_mismatch("speed_counts", data[ANGLE_W + POS_W +: POS_W], want.speed);
			end
			if (flag !== want.speed_new) begin
				report_mismatch("speed_updated", POS_W'(flag), POS_W'(want.speed_new));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index = CFG_ZERO_OFFSET;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	multiturn_checker      track_check = new();
	logic                  sender_idles = 1'b1;
	logic                  receiver_idles = 1'b1;
	logic [ANGLE_W-1:0]    cur_offset = '0;
	logic [ANGLE_W-1:0]    shaft_angle = '0;
	int                    shaft_rate = 5;

	encoder_angle_unwrap_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_sample(input logic [ANGLE_W-1:0] raw);
		while (sender_idles && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(raw);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		track_check.note_sample(raw);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (track_check.due_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		track_check.set_reg(idx, value);
	endtask

	task automatic set_config(input logic [ANGLE_W-1:0] offset,
			input logic [CFG_DATA_W-1:0] window);
		drain_results();
		write_reg(CFG_ZERO_OFFSET, CFG_DATA_W'(offset));
		write_reg(CFG_SPEED_WINDOW, window);
		cfg_valid  <= 1'b0;
		cur_offset = offset;
	endtask

	function automatic int pick_rate();
		int mag;
		case ($urandom_range(0, 3))
			0: mag = $urandom_range(0, 12);
			1: mag = $urandom_range(13, 400);
			2: mag = $urandom_range(401, 1999);
			default: mag = $urandom_range(2000, 2001);
		endcase
		return $urandom_range(0, 1) ? mag : -mag;
	endfunction

	// Mostly a shaft turning at piecewise-constant speed, with random samples mixed in
	task automatic run_motion(input int n_items);
		logic [ANGLE_W-1:0] raw;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				raw = ANGLE_W'($urandom_range(0, TURN_COUNTS - 1));
			end else begin
				if ($urandom_range(0, 24) == 0) shaft_rate = pick_rate();
				shaft_angle = shaft_angle + ANGLE_W'(shaft_rate);
				raw = shaft_angle + cur_offset;
			end
			send_sample(raw);
		end
	endtask

	initial begin : receiver
		int          hold_left;
		int unsigned next_hold_at;
		hold_left    = 0;
		next_hold_at = 400;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) track_check.check_result(m_tdata, m_tuser);
			// long back-pressure so the output register fills and s_tready drops
			if (hold_left == 0 && track_check.checked >= next_hold_at) begin
				hold_left    = 90;
				next_hold_at += 600;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (receiver_idles) begin
				m_tready <= ($urandom_range(0, 99) >= 35);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_CYCLES) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		logic [ANGLE_W-1:0] offset;
		int                 n_items;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: first step is taken from angle zero
		foreach (RAMP_EDGES[i]) send_sample(RAMP_EDGES[i]);
		// Largest offset with a zero window: speed updates on every sample
		set_config(12'd4095, 12'd0);
		send_sample(12'd0);
		send_sample(12'd2048);
		send_sample(12'd4095);
		set_config(12'd2048, 12'd1);
		send_sample(12'd100);
		send_sample(12'd3000);
		send_sample(12'd2048);

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: offset = '0;
				1: offset = '1;
				default: offset = ANGLE_W'($urandom_range(0, TURN_COUNTS - 1));
			endcase
			set_config(offset, PHASE_WINDOWS[p]);
			// phases after a 1023 window start far past the new, short window
			if (p == 0) begin
				n_items = 300;
			end else if (p == 8) begin
				n_items = 150;
			end else begin
				n_items = $urandom_range(80, 120);
			end
			sender_idles   = (p != 3);
			receiver_idles <= (p != 3);
			run_motion(n_items);
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (track_check.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
